// ===== src/imkh_pkg.sv =====
// ----------------------------------------------------------------------------
// imkh_pkg
// Shared types and constants of the indexed min-heap with key update.
// ----------------------------------------------------------------------------
`default_nettype none

package imkh_pkg;

   localparam int CAPACITY_DEF = 64;
   localparam int ID_W         = 16;
   localparam int KEY_W        = 32;
   localparam int ENTRY_W      = ID_W + KEY_W;
   localparam int POS_W        = 6;

   localparam logic [2:0] KIND_LOAD   = 3'd0;
   localparam logic [2:0] KIND_BUILD  = 3'd1;
   localparam logic [2:0] KIND_CHANGE = 3'd2;
   localparam logic [2:0] KIND_DELETE = 3'd3;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
   localparam logic [1:0] STATUS_EMPTY     = 2'd2;
   localparam logic [1:0] STATUS_FULL      = 2'd3;

   localparam logic [4:0] OP_NOP    = 5'd0;
   localparam logic [4:0] OP_START  = 5'd1;
   localparam logic [4:0] OP_LOAD   = 5'd2;
   localparam logic [4:0] OP_SCAN   = 5'd3;
   localparam logic [4:0] OP_CHG    = 5'd4;
   localparam logic [4:0] OP_DEL    = 5'd5;
   localparam logic [4:0] OP_DELA   = 5'd6;
   localparam logic [4:0] OP_BINIT  = 5'd7;
   localparam logic [4:0] OP_BRD    = 5'd8;
   localparam logic [4:0] OP_BGET   = 5'd9;
   localparam logic [4:0] OP_SDCHK  = 5'd10;
   localparam logic [4:0] OP_SDC1   = 5'd11;
   localparam logic [4:0] OP_SDC2   = 5'd12;
   localparam logic [4:0] OP_SDCMP  = 5'd13;
   localparam logic [4:0] OP_SUCHK  = 5'd14;
   localparam logic [4:0] OP_SUCMP  = 5'd15;
   localparam logic [4:0] OP_FINRD  = 5'd16;
   localparam logic [4:0] OP_FIN    = 5'd17;

   typedef struct packed {
      logic [4:0] op;
      logic [1:0] code;
   } cmd_type;

   typedef struct packed {
      logic [2:0] kind;
      logic       full;
      logic       empty;
      logic       match;
      logic       scan_end;
      logic       grew;
      logic       del_last;
      logic       b_zero;
      logic       leaf;
      logic       has_c2;
      logic       a_gt_b;
      logic       at_root;
      logic       a_gt_rd;
      logic       out_busy;
   } stat_type;

endpackage

`default_nettype wire

// ===== src/indexed_min_heap_key_update.sv =====
// ----------------------------------------------------------------------------
// indexed_min_heap_key_update
// Binary min-heap of (id, key) entries with load, build, key change,
// delete and peek operations, one result per request.
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_stall  kind, id, key
//   rsp      out        rsp_valid / rsp_stall  status, position, min_id,
//                                              min_key, count
//
// One request is processed at a time, each step one read or write of the
// single-port entry memory. A change or delete first scans the ids for a
// match, then sifts the entry down or up the tree; build sifts down each
// internal slot from the last one back to the root.
// Reset clears the entry count and the result valid flag; no clearing pass.
// A new request is taken while an earlier result is still stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module indexed_min_heap_key_update
   import imkh_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEF,
   parameter int CW       = $clog2(CAPACITY + 1)
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_stall,
   input  wire logic [2:0]              req_kind,
   input  wire logic [ID_W-1:0]         req_id,
   input  wire logic signed [KEY_W-1:0] req_key,
   output logic                         rsp_valid,
   input  wire logic                    rsp_stall,
   output logic [1:0]                   rsp_status,
   output logic [POS_W-1:0]             rsp_position,
   output logic [ID_W-1:0]              rsp_min_id,
   output logic signed [KEY_W-1:0]      rsp_min_key,
   output logic [CW-1:0]                rsp_count
);

   cmd_type  cmd;
   stat_type stat;

   imkh_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   imkh_dp #(
      .CAPACITY (CAPACITY),
      .CW       (CW)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .stat         (stat),
      .req_kind     (req_kind),
      .req_id       (req_id),
      .req_key      (req_key),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_status   (rsp_status),
      .rsp_position (rsp_position),
      .rsp_min_id   (rsp_min_id),
      .rsp_min_key  (rsp_min_key),
      .rsp_count    (rsp_count)
   );

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_count <= CW'(CAPACITY)))
      else $error("entry count above capacity");

   a_full_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == STATUS_FULL)) |-> (rsp_count == CW'(CAPACITY)))
      else $error("full status with free slots");

   a_empty_min: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_count == '0)) |-> ((rsp_min_id == '0) && (rsp_min_key == '0)))
      else $error("minimum reported on empty heap");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("second transaction taken while busy");

endmodule

`default_nettype wire

// ===== src/imkh_ctrl.sv =====
// ----------------------------------------------------------------------------
// imkh_ctrl
// Sequencer that steps the heap datapath through each operation.
// ----------------------------------------------------------------------------
`default_nettype none

module imkh_ctrl
   import imkh_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     req_valid,
   output logic          req_stall,
   input  wire stat_type stat,
   output cmd_type       cmd
);

   localparam logic [4:0] S_IDLE  = 5'd0;
   localparam logic [4:0] S_DISP  = 5'd1;
   localparam logic [4:0] S_SCAN  = 5'd2;
   localparam logic [4:0] S_CHG   = 5'd3;
   localparam logic [4:0] S_DEL1  = 5'd4;
   localparam logic [4:0] S_DEL2  = 5'd5;
   localparam logic [4:0] S_BCHK  = 5'd6;
   localparam logic [4:0] S_BRD   = 5'd7;
   localparam logic [4:0] S_BGET  = 5'd8;
   localparam logic [4:0] S_SDCHK = 5'd9;
   localparam logic [4:0] S_SDC1  = 5'd10;
   localparam logic [4:0] S_SDC2  = 5'd11;
   localparam logic [4:0] S_SDCMP = 5'd12;
   localparam logic [4:0] S_SUCHK = 5'd13;
   localparam logic [4:0] S_SUCMP = 5'd14;
   localparam logic [4:0] S_FINRD = 5'd15;
   localparam logic [4:0] S_FIN   = 5'd16;

   logic [4:0] state_ff, state_in;
   logic [1:0] code_ff, code_in;
   logic       bld_ff, bld_in;
   logic [4:0] sift_done;

   assign req_stall = (state_ff != S_IDLE);
   assign sift_done = bld_ff ? S_BCHK : S_FINRD;

   always_comb begin
      state_in = state_ff;
      code_in  = code_ff;
      bld_in   = bld_ff;
      cmd.op   = OP_NOP;
      cmd.code = code_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.op   = OP_START;
               state_in = S_DISP;
               code_in  = STATUS_OK;
               bld_in   = 1'b0;
            end
         end
         S_DISP: begin
            case (stat.kind)
               KIND_LOAD: begin
                  state_in = S_FINRD;
                  if (stat.full) begin
                     code_in = STATUS_FULL;
                  end else begin
                     cmd.op = OP_LOAD;
                  end
               end
               KIND_BUILD: begin
                  cmd.op   = OP_BINIT;
                  bld_in   = 1'b1;
                  state_in = S_BCHK;
               end
               KIND_CHANGE, KIND_DELETE: begin
                  if (stat.empty) begin
                     code_in  = STATUS_EMPTY;
                     state_in = S_FINRD;
                  end else begin
                     state_in = S_SCAN;
                  end
               end
               default: begin
                  if (stat.empty) begin
                     code_in = STATUS_EMPTY;
                  end
                  state_in = S_FINRD;
               end
            endcase
         end
         S_SCAN: begin
            cmd.op = OP_SCAN;
            if (stat.match) begin
               state_in = (stat.kind == KIND_CHANGE) ? S_CHG : S_DEL1;
            end else if (stat.scan_end) begin
               code_in  = STATUS_NOT_FOUND;
               state_in = S_FINRD;
            end
         end
         S_CHG: begin
            cmd.op   = OP_CHG;
            state_in = stat.grew ? S_SDCHK : S_SUCHK;
         end
         S_DEL1: begin
            cmd.op   = OP_DEL;
            state_in = S_DEL2;
         end
         S_DEL2: begin
            cmd.op   = OP_DELA;
            state_in = stat.del_last ? S_FINRD : S_SDCHK;
         end
         S_BCHK: begin
            state_in = stat.b_zero ? S_FINRD : S_BRD;
         end
         S_BRD: begin
            cmd.op   = OP_BRD;
            state_in = S_BGET;
         end
         S_BGET: begin
            cmd.op   = OP_BGET;
            state_in = S_SDCHK;
         end
         S_SDCHK: begin
            cmd.op   = OP_SDCHK;
            state_in = stat.leaf ? sift_done : S_SDC1;
         end
         S_SDC1: begin
            cmd.op   = OP_SDC1;
            state_in = stat.has_c2 ? S_SDC2 : S_SDCMP;
         end
         S_SDC2: begin
            cmd.op   = OP_SDC2;
            state_in = S_SDCMP;
         end
         S_SDCMP: begin
            cmd.op   = OP_SDCMP;
            state_in = stat.a_gt_b ? S_SDCHK : sift_done;
         end
         S_SUCHK: begin
            cmd.op   = OP_SUCHK;
            state_in = stat.at_root ? S_FINRD : S_SUCMP;
         end
         S_SUCMP: begin
            cmd.op   = OP_SUCMP;
            state_in = stat.a_gt_rd ? S_FINRD : S_SUCHK;
         end
         S_FINRD: begin
            cmd.op   = OP_FINRD;
            state_in = S_FIN;
         end
         S_FIN: begin
            if (!stat.out_busy) begin
               cmd.op   = OP_FIN;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         code_ff  <= STATUS_OK;
         bld_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         code_ff  <= code_in;
         bld_ff   <= bld_in;
      end
   end

endmodule

`default_nettype wire

// ===== src/imkh_dp.sv =====
// ----------------------------------------------------------------------------
// imkh_dp
// Heap storage, working registers and result register of the heap.
// ----------------------------------------------------------------------------
`default_nettype none

module imkh_dp
   import imkh_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEF,
   parameter int CW       = $clog2(CAPACITY + 1)
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire cmd_type                 cmd,
   output stat_type                     stat,
   input  wire logic [2:0]              req_kind,
   input  wire logic [ID_W-1:0]         req_id,
   input  wire logic signed [KEY_W-1:0] req_key,
   output logic                         rsp_valid,
   input  wire logic                    rsp_stall,
   output logic [1:0]                   rsp_status,
   output logic [POS_W-1:0]             rsp_position,
   output logic [ID_W-1:0]              rsp_min_id,
   output logic signed [KEY_W-1:0]      rsp_min_key,
   output logic [CW-1:0]                rsp_count
);

   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int PW = (AW > POS_W) ? AW : POS_W;

   logic [ENTRY_W-1:0] mem [CAPACITY];

   logic [2:0]         kind_ff, kind_in;
   logic [ID_W-1:0]    id_ff, id_in;
   logic [KEY_W-1:0]   key_ff, key_in;
   logic [CW-1:0]      cnt_ff, cnt_in;
   logic [CW-1:0]      s_ff, s_in;
   logic               v_ff, v_in;
   logic [AW-1:0]      i_ff, i_in;
   logic [AW:0]        c_ff, c_in;
   logic [CW-1:0]      b_ff, b_in;
   logic [ENTRY_W-1:0] a_ff, a_in;
   logic [ENTRY_W-1:0] bb_ff, bb_in;
   logic [ENTRY_W-1:0] rd_ff;
   logic [POS_W-1:0]   pos_ff, pos_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [1:0]         rsp_status_ff, rsp_status_in;
   logic [POS_W-1:0]   rsp_pos_ff, rsp_pos_in;
   logic [ENTRY_W-1:0] rsp_min_ff, rsp_min_in;
   logic [CW-1:0]      rsp_cnt_ff, rsp_cnt_in;

   logic               we, re;
   logic [AW-1:0]      wa, ra;
   logic [ENTRY_W-1:0] wd;

   logic [ID_W-1:0]    rd_id;
   logic [KEY_W-1:0]   rd_key, a_key, bb_key;
   logic [AW:0]        c_first, c_second, cnt_w;
   logic [AW-1:0]      parent;
   logic [PW-1:0]      i_wide;
   logic [POS_W-1:0]   i_pos;
   logic               is_change;

   assign rd_id     = rd_ff[ENTRY_W-1:KEY_W];
   assign rd_key    = rd_ff[KEY_W-1:0];
   assign a_key     = a_ff[KEY_W-1:0];
   assign bb_key    = bb_ff[KEY_W-1:0];
   assign c_first   = {i_ff, 1'b1};
   assign c_second  = c_ff + (AW+1)'(1);
   assign cnt_w     = (AW+1)'(cnt_ff);
   assign parent    = (i_ff - AW'(1)) >> 1;
   assign i_wide    = PW'(i_ff);
   assign i_pos     = i_wide[POS_W-1:0];
   assign is_change = (kind_ff == KIND_CHANGE);

   always_comb begin
      stat.kind     = kind_ff;
      stat.full     = (cnt_ff >= CW'(CAPACITY));
      stat.empty    = (cnt_ff == '0);
      stat.match    = v_ff && (rd_id == id_ff);
      stat.scan_end = !stat.match && (s_ff >= cnt_ff);
      stat.grew     = $signed(key_ff) > $signed(rd_key);
      stat.del_last = (CW'(i_ff) >= cnt_ff);
      stat.b_zero   = (b_ff == '0);
      stat.leaf     = (c_first >= cnt_w);
      stat.has_c2   = (c_second < cnt_w);
      stat.a_gt_b   = $signed(a_key) > $signed(bb_key);
      stat.at_root  = (i_ff == '0);
      stat.a_gt_rd  = $signed(a_key) > $signed(rd_key);
      stat.out_busy = rsp_valid_ff && rsp_stall;
   end

   always_comb begin
      kind_in       = kind_ff;
      id_in         = id_ff;
      key_in        = key_ff;
      cnt_in        = cnt_ff;
      s_in          = s_ff;
      v_in          = v_ff;
      i_in          = i_ff;
      c_in          = c_ff;
      b_in          = b_ff;
      a_in          = a_ff;
      bb_in         = bb_ff;
      pos_in        = pos_ff;
      rsp_status_in = rsp_status_ff;
      rsp_pos_in    = rsp_pos_ff;
      rsp_min_in    = rsp_min_ff;
      rsp_cnt_in    = rsp_cnt_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      we            = 1'b0;
      wa            = i_ff;
      wd            = a_ff;
      re            = 1'b0;
      ra            = '0;
      case (cmd.op)
         OP_START: begin
            kind_in = req_kind;
            id_in   = req_id;
            key_in  = req_key;
            s_in    = '0;
            v_in    = 1'b0;
            pos_in  = '0;
         end
         OP_LOAD: begin
            we     = 1'b1;
            wa     = cnt_ff[AW-1:0];
            wd     = {id_ff, key_ff};
            cnt_in = cnt_ff + CW'(1);
         end
         OP_SCAN: begin
            if (!stat.match && (s_ff < cnt_ff)) begin
               re   = 1'b1;
               ra   = s_ff[AW-1:0];
               s_in = s_ff + CW'(1);
               v_in = 1'b1;
            end
         end
         OP_CHG: begin
            i_in = AW'(s_ff - CW'(1));
            a_in = {id_ff, key_ff};
         end
         OP_DEL: begin
            i_in   = AW'(s_ff - CW'(1));
            re     = 1'b1;
            ra     = AW'(cnt_ff - CW'(1));
            cnt_in = cnt_ff - CW'(1);
         end
         OP_DELA, OP_BGET: begin
            a_in = rd_ff;
         end
         OP_BINIT: begin
            b_in = cnt_ff >> 1;
         end
         OP_BRD: begin
            i_in = AW'(b_ff - CW'(1));
            b_in = b_ff - CW'(1);
            re   = 1'b1;
            ra   = AW'(b_ff - CW'(1));
         end
         OP_SDCHK: begin
            c_in = c_first;
            if (stat.leaf) begin
               we = 1'b1;
               if (is_change) begin
                  pos_in = i_pos;
               end
            end else begin
               re = 1'b1;
               ra = c_first[AW-1:0];
            end
         end
         OP_SDC1: begin
            bb_in = rd_ff;
            if (stat.has_c2) begin
               re = 1'b1;
               ra = c_second[AW-1:0];
            end
         end
         OP_SDC2: begin
            if ($signed(rd_key) < $signed(bb_key)) begin
               bb_in = rd_ff;
               c_in  = c_second;
            end
         end
         OP_SDCMP: begin
            we = 1'b1;
            if (stat.a_gt_b) begin
               wd   = bb_ff;
               i_in = c_ff[AW-1:0];
            end else if (is_change) begin
               pos_in = i_pos;
            end
         end
         OP_SUCHK: begin
            if (stat.at_root) begin
               we = 1'b1;
               if (is_change) begin
                  pos_in = '0;
               end
            end else begin
               re = 1'b1;
               ra = parent;
            end
         end
         OP_SUCMP: begin
            we = 1'b1;
            if (stat.a_gt_rd) begin
               if (is_change) begin
                  pos_in = i_pos;
               end
            end else begin
               wd   = rd_ff;
               i_in = parent;
            end
         end
         OP_FINRD: begin
            re = 1'b1;
            ra = '0;
         end
         OP_FIN: begin
            rsp_valid_in  = 1'b1;
            rsp_status_in = cmd.code;
            rsp_pos_in    = pos_ff;
            rsp_min_in    = (cnt_ff != '0) ? rd_ff : '0;
            rsp_cnt_in    = cnt_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[wa] <= wd;
      end
      if (re) begin
         rd_ff <= mem[ra];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      kind_ff       <= kind_in;
      id_ff         <= id_in;
      key_ff        <= key_in;
      s_ff          <= s_in;
      v_ff          <= v_in;
      i_ff          <= i_in;
      c_ff          <= c_in;
      b_ff          <= b_in;
      a_ff          <= a_in;
      bb_ff         <= bb_in;
      pos_ff        <= pos_in;
      rsp_status_ff <= rsp_status_in;
      rsp_pos_ff    <= rsp_pos_in;
      rsp_min_ff    <= rsp_min_in;
      rsp_cnt_ff    <= rsp_cnt_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_position = rsp_pos_ff;
   assign rsp_min_id   = rsp_min_ff[ENTRY_W-1:KEY_W];
   assign rsp_min_key  = rsp_min_ff[KEY_W-1:0];
   assign rsp_count    = rsp_cnt_ff;

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking testbench of the indexed min-heap with key update. A driver
// sends load, build, change-key, delete and peek requests from a queue, a
// monitor compares each response in all its fields with a software heap model.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
   import imkh_pkg::*;

   localparam int HEAP_SIZE = 64;
   localparam logic [2:0] KIND_PEEK = 3'd4;

   typedef struct packed {
      logic [2:0]              kind;
      logic [ID_W-1:0]         id;
      logic signed [KEY_W-1:0] key;
   } heap_req_type;

   typedef struct packed {
      logic [1:0]              status;
      logic [POS_W-1:0]        position;
      logic [ID_W-1:0]         min_id;
      logic signed [KEY_W-1:0] min_key;
      logic [6:0]              count;
   } heap_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [2:0] req_kind = '0;
   logic [ID_W-1:0] req_id = '0;
   logic signed [KEY_W-1:0] req_key = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [1:0] rsp_status;
   logic [POS_W-1:0] rsp_position;
   logic [ID_W-1:0] rsp_min_id;
   logic signed [KEY_W-1:0] rsp_min_key;
   logic [6:0] rsp_count;

   heap_req_type pending_reqs[$];
   heap_rsp_type expected_rsps[$];
   logic [ID_W-1:0] heap_ids[HEAP_SIZE];
   logic signed [KEY_W-1:0] heap_keys[HEAP_SIZE];
   int heap_count = 0;
   int error_count = 0;
   int accepted_reqs = 0;
   int checked_rsps = 0;
   int cycle_count = 0;
   bit stimulus_done = 1'b0;
   int hold_cycles = 0;
   int status_seen[4] = '{0, 0, 0, 0};

   indexed_min_heap_key_update i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_kind(req_kind), .req_id(req_id), .req_key(req_key),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_status(rsp_status), .rsp_position(rsp_position),
      .rsp_min_id(rsp_min_id), .rsp_min_key(rsp_min_key),
      .rsp_count(rsp_count)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   function automatic void swap_entries(int a, int b);
      logic [ID_W-1:0] tid;
      logic signed [KEY_W-1:0] tkey;
      tid = heap_ids[a]; tkey = heap_keys[a];
      heap_ids[a] = heap_ids[b]; heap_keys[a] = heap_keys[b];
      heap_ids[b] = tid; heap_keys[b] = tkey;
   endfunction

   function automatic int pick_child(int i);
      int c;
      c = 2 * i + 1;
      if (c >= heap_count) return heap_count;
      if (c + 1 >= heap_count || !(heap_keys[c] > heap_keys[c + 1])) return c;
      return c + 1;
   endfunction

   function automatic int sift_down(int i);
      int c;
      c = pick_child(i);
      while (c < heap_count && heap_keys[i] > heap_keys[c]) begin
         swap_entries(c, i);
         i = c;
         c = pick_child(i);
      end
      return i;
   endfunction

   function automatic int sift_up(int i);
      int p;
      while (i != 0) begin
         p = (i - 1) / 2;
         if (heap_keys[i] > heap_keys[p]) break;
         swap_entries(p, i);
         i = p;
      end
      return i;
   endfunction

   function automatic heap_rsp_type apply_heap_request(heap_req_type r);
      heap_rsp_type res;
      int slot;
      int pos;
      logic signed [KEY_W-1:0] old_key;
      res = '0;
      pos = 0;
      if (r.kind == KIND_LOAD) begin
         if (heap_count >= HEAP_SIZE) begin
            res.status = STATUS_FULL;
         end else begin
            heap_ids[heap_count] = r.id;
            heap_keys[heap_count] = r.key;
            heap_count++;
         end
      end else if (r.kind == KIND_BUILD) begin
         for (int i = heap_count / 2; i > 0; i--) void'(sift_down(i - 1));
      end else if (r.kind == KIND_CHANGE || r.kind == KIND_DELETE) begin
         if (heap_count == 0) begin
            res.status = STATUS_EMPTY;
         end else begin
            slot = heap_count;
            for (int i = heap_count - 1; i >= 0; i--)
               if (heap_ids[i] == r.id) slot = i;
            if (slot >= heap_count) begin
               res.status = STATUS_NOT_FOUND;
            end else if (r.kind == KIND_CHANGE) begin
               old_key = heap_keys[slot];
               heap_keys[slot] = r.key;
               if (r.key > old_key) pos = sift_down(slot);
               else pos = sift_up(slot);
            end else begin
               swap_entries(slot, heap_count - 1);
               heap_count--;
               if (slot < heap_count) void'(sift_down(slot));
            end
         end
      end else if (heap_count == 0) begin
         res.status = STATUS_EMPTY;
      end
      res.position = pos[POS_W-1:0];
      if (heap_count > 0) begin
         res.min_id = heap_ids[0];
         res.min_key = heap_keys[0];
      end
      res.count = heap_count[6:0];
      return res;
   endfunction

   function automatic void add_req(logic [2:0] kind, logic [ID_W-1:0] id,
                                   logic signed [KEY_W-1:0] key);
      heap_req_type r;
      r.kind = kind; r.id = id; r.key = key;
      pending_reqs.push_back(r);
   endfunction

   // Ids are drawn from a small pool so that changes and deletes usually hit.
   function automatic logic [ID_W-1:0] rand_id();
      if ($urandom_range(0, 9) == 0) return ID_W'($urandom);
      return ID_W'($urandom_range(0, 40));
   endfunction

   function automatic logic signed [KEY_W-1:0] rand_key();
      case ($urandom_range(0, 4))
         0: return 32'sh7fffffff;
         1: return 32'sh80000000;
         2: return KEY_W'($urandom_range(0, 15)) - 8;
         default: return KEY_W'($urandom);
      endcase
   endfunction

   initial begin
      add_req(KIND_PEEK, 16'hffff, 32'sh7fffffff);
      add_req(KIND_CHANGE, 16'h0001, '0);
      add_req(KIND_DELETE, 16'h0001, '0);
      add_req(KIND_BUILD, '0, '0);
      add_req(3'd7, 16'h0000, 32'sh80000000);
      add_req(KIND_LOAD, 16'hffff, 32'sh7fffffff);
      add_req(KIND_LOAD, 16'h0000, 32'sh80000000);
      add_req(KIND_LOAD, 16'h0005, 32'sh00010000);
      add_req(KIND_LOAD, 16'h0005, 32'sh00010000);
      add_req(KIND_LOAD, 16'haaaa, 32'shffff0000);
      add_req(KIND_BUILD, '0, '0);
      add_req(KIND_CHANGE, 16'h0005, 32'sh00010000);
      add_req(KIND_CHANGE, 16'hffff, 32'sh80000000);
      add_req(KIND_CHANGE, 16'hffff, 32'sh7fffffff);
      add_req(KIND_CHANGE, 16'h1234, '0);
      add_req(KIND_DELETE, 16'h0005, '0);
      add_req(KIND_DELETE, 16'haaaa, '0);
      add_req(3'd5, '0, '0);
      add_req(3'd6, '0, '0);
      for (int i = 0; i < 66; i++) add_req(KIND_LOAD, rand_id(), rand_key());
      add_req(KIND_BUILD, '0, '0);
      for (int i = 0; i < 1000; i++) begin
         case ($urandom_range(0, 19))
            0, 1, 2, 3, 4, 5: add_req(KIND_LOAD, rand_id(), rand_key());
            6: add_req(KIND_BUILD, ID_W'($urandom), KEY_W'($urandom));
            7, 8, 9, 10, 11: add_req(KIND_CHANGE, rand_id(), rand_key());
            12, 13, 14, 15, 16: add_req(KIND_DELETE, rand_id(), KEY_W'($urandom));
            default: add_req(3'($urandom_range(4, 7)), ID_W'($urandom), KEY_W'($urandom));
         endcase
      end
      repeat (2) @(posedge clock);
      reset <= 1'b0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         cycle_count <= cycle_count + 1;
         if (req_valid && !req_stall) begin
            expected_rsps.push_back(apply_heap_request('{req_kind, req_id, req_key}));
            accepted_reqs <= accepted_reqs + 1;
         end
         if (!req_valid || !req_stall) begin
            if (pending_reqs.size() > 0 &&
                (cycle_count < 3000 || $urandom_range(0, 99) >= 21)) begin
               heap_req_type r;
               r = pending_reqs.pop_front();
               req_valid <= 1'b1;
               req_kind <= r.kind;
               req_id <= r.id;
               req_key <= r.key;
            end else begin
               req_valid <= 1'b0;
               if (pending_reqs.size() == 0) stimulus_done <= 1'b1;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            heap_rsp_type got;
            heap_rsp_type exp;
            got = '{rsp_status, rsp_position, rsp_min_id, rsp_min_key, rsp_count};
            if (expected_rsps.size() == 0) begin
               $display("%0t: unexpected response %p", $time, got);
               error_count <= error_count + 1;
            end else begin
               exp = expected_rsps.pop_front();
               checked_rsps <= checked_rsps + 1;
               status_seen[exp.status] <= status_seen[exp.status] + 1;
               if (got !== exp) begin
                  $display("%0t: mismatch expected %p actual %p", $time, exp, got);
                  error_count <= error_count + 1;
               end
            end
         end
         if (cycle_count == 6000) hold_cycles <= 2000;
         if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= (cycle_count >= 3000) && ($urandom_range(0, 99) < 21);
         end
      end
   end

   initial begin
      wait (!reset);
      wait (stimulus_done && !req_valid && expected_rsps.size() == 0);
      repeat (200) @(posedge clock);
      $display("Checked %0d responses for %0d requests.", checked_rsps, accepted_reqs);
      $display("Status counts ok/not found/empty/full: %0d %0d %0d %0d",
               status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
      if (error_count == 0 && expected_rsps.size() == 0) begin
         $display("indexed_min_heap_key_update verification clean");
      end else begin
         $display("indexed_min_heap_key_update verification failed");
      end
      $finish;
   end

   initial begin
      #20000000;
      $display("indexed_min_heap_key_update verification failed");
      $finish;
   end

endmodule

// ===== indexed_min_heap_key_update.f =====
src/imkh_pkg.sv
src/imkh_ctrl.sv
src/imkh_dp.sv
src/indexed_min_heap_key_update.sv
tb/testbench.sv
